>>> rtl/erc_pkg.sv
package erc_pkg;

    // default depth of the rotation chain
    localparam int CORDIC_STAGES_DEF = 32;

    // field widths
    localparam int LAT_W  = 24;
    localparam int SEMI_W = 34;
    localparam int E2_W   = 32;
    localparam int RAD_W  = 40;

    // internal widths and chain lengths
    localparam int ANG_W      = 44;
    localparam int ROOT_W     = 64;
    localparam int ROOT_STEPS = 32;
    localparam int DIV_N_W    = 97;
    localparam int DIV_D_W    = 64;
    localparam int DIV_STEPS  = DIV_N_W;

    typedef logic signed [ANG_W-1:0] ang_t;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_SEMI_MAJOR = 1'b0,
        CFG_ECC_SQ     = 1'b1
    } cfg_index_t;

    localparam logic [SEMI_W-1:0] SEMI_RESET = 34'd6378137000;
    localparam logic [E2_W-1:0]   E2_RESET   = 32'd28752143;

    localparam logic [22:0] QUARTER_TURN_Q16 = 23'd5898240;
    localparam logic [23:0] HALF_TURN_Q16    = 24'd11796480;
    localparam ang_t        K_Q40            = 44'sd667681663043;

    // restoring division, used only for constants
    function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], n[i]};
            if (r >= d) begin
                r = r - d;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(1/m) in q60 from its alternating series
    function automatic logic [63:0] atan_inv_q60(input logic [63:0] m);
        logic [63:0] t;
        logic [63:0] sum;
        logic [63:0] term;
        t = udiv(64'd1 << 60, m);
        sum = '0;
        for (int k = 0; k < 64; k++) begin
            if (t != 64'd0) begin
                term = udiv(t, 64'(2 * k + 1));
                if ((k & 1) == 0) begin
                    sum = sum + term;
                end else begin
                    sum = sum - term;
                end
                t = udiv(udiv(t, m), m);
            end
        end
        return sum;
    endfunction

    function automatic logic [63:0] pi4_q60();
        return 64'd4 * atan_inv_q60(64'd5) - atan_inv_q60(64'd239);
    endfunction

    // atan(2^-i) in q40
    function automatic logic [63:0] atan_pow2_q40(input int i);
        logic [63:0] v;
        if (i == 0) begin
            v = pi4_q60();
        end else if (i < 60) begin
            v = atan_inv_q60(64'd1 << i);
        end else begin
            v = '0;
        end
        return (v + (64'd1 << 19)) >> 20;
    endfunction

    // pi/180 in q45
    function automatic logic [63:0] deg2rad_q45();
        return udiv(((64'd4 * pi4_q60()) >> 15) + 64'd90, 64'd180);
    endfunction

    localparam logic [39:0] DEG2RAD_Q45 = 40'(deg2rad_q45());

    // rotation cell state
    typedef struct packed {
        ang_t x;
        ang_t y;
        ang_t z;
    } cordic_t;

    // square root lane state
    typedef struct packed {
        logic [ROOT_W-1:0] n;
        logic [ROOT_W-1:0] r;
    } root_t;

    // long division lane state
    typedef struct packed {
        logic [DIV_N_W-1:0] num;
        logic [DIV_D_W-1:0] den;
        logic [DIV_D_W-1:0] rem;
        logic [RAD_W-1:0]   quo;
        logic               ovf;
    } div_lane_t;

    // one result
    typedef struct packed {
        logic [RAD_W-1:0] meridional;
        logic [RAD_W-1:0] transverse;
        logic [RAD_W-1:0] conformal;
        logic             saturated;
    } result_t;

endpackage

>>> rtl/erc_cordic_cell.sv
module erc_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic             aclk,
    input  logic             en,
    input  erc_pkg::cordic_t in_data,
    output erc_pkg::cordic_t out_data
);

    localparam erc_pkg::ang_t ATAN = erc_pkg::ang_t'(erc_pkg::atan_pow2_q40(STAGE));

    erc_pkg::ang_t    xi;
    erc_pkg::ang_t    yi;
    erc_pkg::ang_t    zi;
    erc_pkg::ang_t    dx;
    erc_pkg::ang_t    dy;
    erc_pkg::cordic_t cell_next;
    erc_pkg::cordic_t cell_reg;

    // one micro-rotation toward zero residual angle
    always_comb begin
        xi = in_data.x;
        yi = in_data.y;
        zi = in_data.z;
        dx = yi >>> STAGE;
        dy = xi >>> STAGE;
        if (!zi[erc_pkg::ANG_W-1]) begin
            cell_next.x = xi - dx;
            cell_next.y = yi + dy;
            cell_next.z = zi - ATAN;
        end else begin
            cell_next.x = xi + dx;
            cell_next.y = yi - dy;
            cell_next.z = zi + ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign out_data = cell_reg;

endmodule

>>> rtl/erc_sqrt_cell.sv
module erc_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic           aclk,
    input  logic           en,
    input  erc_pkg::root_t in_data,
    output erc_pkg::root_t out_data
);

    localparam logic [erc_pkg::ROOT_W-1:0] BIT = 64'd1 << (62 - 2 * STEP);

    logic [erc_pkg::ROOT_W-1:0] trial;
    erc_pkg::root_t             cell_next;
    erc_pkg::root_t             cell_reg;

    // one result bit of the digit-by-digit root
    always_comb begin
        trial = in_data.r + BIT;
        if (in_data.n >= trial) begin
            cell_next.n = in_data.n - trial;
            cell_next.r = (in_data.r >> 1) + BIT;
        end else begin
            cell_next.n = in_data.n;
            cell_next.r = in_data.r >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign out_data = cell_reg;

endmodule

>>> rtl/erc_div_cell.sv
module erc_div_cell #(
    parameter int STEP = 0
) (
    input  logic               aclk,
    input  logic               en,
    input  erc_pkg::div_lane_t in_data,
    output erc_pkg::div_lane_t out_data
);

    logic [erc_pkg::DIV_D_W:0] trial;
    logic                      ge;
    erc_pkg::div_lane_t        cell_next;
    erc_pkg::div_lane_t        cell_reg;

    // one quotient bit, overflow once a bit leaves the result width
    always_comb begin
        trial = {in_data.rem, in_data.num[erc_pkg::DIV_N_W-1-STEP]};
        ge    = trial >= {1'b0, in_data.den};
        cell_next     = in_data;
        cell_next.rem = ge ? erc_pkg::DIV_D_W'(trial - {1'b0, in_data.den})
                           : trial[erc_pkg::DIV_D_W-1:0];
        cell_next.quo = {in_data.quo[erc_pkg::RAD_W-2:0], ge};
        cell_next.ovf = in_data.ovf | in_data.quo[erc_pkg::RAD_W-1];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign out_data = cell_reg;

endmodule

>>> rtl/ellipsoid_radii_of_curvature.sv
// Ellipsoid radii of curvature: each request carries one geodetic latitude
// (degrees, q16) and yields the meridional, transverse and conformal-sphere
// radii in mm for the ellipsoid held in the two configuration registers,
// with saturated set when any radius clamps at 2^40-1. One request is taken
// per cycle while the chain is not stalled; each result passes through the
// rotation chain, the 32-cell root chain and the 97-cell division chain.
// The whole chain stalls only when both output slots hold results not yet
// taken. Configuration must be written only while no request is in flight;
// the user is bound by this, and the block itself does not enforce it.
module ellipsoid_radii_of_curvature #(
    parameter int CORDIC_STAGES = erc_pkg::CORDIC_STAGES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [erc_pkg::LAT_W-1:0] s_latitude_q16,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [erc_pkg::RAD_W-1:0]       m_meridional_radius_mm,
    output logic [erc_pkg::RAD_W-1:0]       m_transverse_radius_mm,
    output logic [erc_pkg::RAD_W-1:0]       m_conformal_radius_mm,
    output logic                            m_saturated,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [0:0]                      cfg_index,
    input  logic [erc_pkg::SEMI_W-1:0]      cfg_data
);

    localparam int ROOT_STEPS = erc_pkg::ROOT_STEPS;
    localparam int DIV_STEPS  = erc_pkg::DIV_STEPS;
    localparam int PIPE_LAT   = 1 + CORDIC_STAGES + 3 + ROOT_STEPS + 2 + DIV_STEPS;

    logic adv;

    // configuration registers
    logic [erc_pkg::SEMI_W-1:0] semi_reg;
    logic [erc_pkg::E2_W-1:0]   e2_reg;
    logic [32:0]                om;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            semi_reg <= erc_pkg::SEMI_RESET;
            e2_reg   <= erc_pkg::E2_RESET;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == erc_pkg::CFG_SEMI_MAJOR) begin
                semi_reg <= cfg_data;
            end else if (cfg_index == erc_pkg::CFG_ECC_SQ) begin
                e2_reg <= cfg_data[erc_pkg::E2_W-1:0];
            end
        end
    end

    assign om = 33'h1_0000_0000 - {1'b0, e2_reg};

    // valid bits along the chain
    logic [PIPE_LAT-1:0] vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[PIPE_LAT-2:0], s_valid};
        end
    end

    assign s_ready = adv;

    // latitude folded to 0..90 degrees, then to radians q40
    logic [23:0]   lat_mag;
    logic [22:0]   lat_red;
    logic [62:0]   ang_prod;
    erc_pkg::ang_t z0_reg;

    always_comb begin
        lat_mag = s_latitude_q16[23] ? 24'(-s_latitude_q16) : 24'(s_latitude_q16);
        lat_red = (lat_mag > {1'b0, erc_pkg::QUARTER_TURN_Q16})
                ? 23'(erc_pkg::HALF_TURN_Q16 - lat_mag) : lat_mag[22:0];
        ang_prod = {40'd0, lat_red} * {23'd0, erc_pkg::DEG2RAD_Q45};
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            z0_reg <= erc_pkg::ang_t'(ang_prod[62:21]);
        end
    end

    // rotation chain
    erc_pkg::cordic_t cd [0:CORDIC_STAGES];

    assign cd[0].x = erc_pkg::K_Q40;
    assign cd[0].y = '0;
    assign cd[0].z = z0_reg;

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
        erc_cordic_cell #(.STAGE(i)) u_cell (
            .aclk    (aclk),
            .en      (adv),
            .in_data (cd[i]),
            .out_data(cd[i+1])
        );
    end

    // sine clamped and rounded, then squared
    erc_pkg::ang_t y_end;
    logic [40:0]   y_cl;
    logic [32:0]   s_wide;
    logic [31:0]   s31;
    logic [63:0]   s_sq;
    logic [32:0]   s2_reg;

    always_comb begin
        y_end = cd[CORDIC_STAGES].y;
        if (y_end[erc_pkg::ANG_W-1]) begin
            y_cl = '0;
        end else if (y_end > erc_pkg::ang_t'(44'sd1 <<< 40)) begin
            y_cl = 41'd1 << 40;
        end else begin
            y_cl = y_end[40:0];
        end
        s_wide = 33'(({1'b0, y_cl} + 42'd256) >> 9);
        s31    = (s_wide > 33'h0_8000_0000) ? 32'h8000_0000 : s_wide[31:0];
        s_sq   = {32'd0, s31} * {32'd0, s31};
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_reg <= 33'((65'(s_sq) + 65'(64'd1 << 29)) >> 30);
        end
    end

    // e2 * s^2
    logic [63:0] p_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            p_reg <= 64'({32'd0, e2_reg} * {31'd0, s2_reg});
        end
    end

    // x = 1 - e2 sin^2 in q32
    logic [32:0] t_q32;
    logic [32:0] xq_reg;

    assign t_q32 = 33'((65'(p_reg) + 65'(64'd1 << 31)) >> 32);

    always_ff @(posedge aclk) begin
        if (adv) begin
            xq_reg <= 33'h1_0000_0000 - t_q32;
        end
    end

    // root chains for sqrt(x) and sqrt(1-e2)
    erc_pkg::root_t rx [0:ROOT_STEPS];
    erc_pkg::root_t rs [0:ROOT_STEPS];
    logic [32:0]    xq_pipe_reg [1:ROOT_STEPS];

    assign rx[0].n = 64'(xq_reg) << 30;
    assign rx[0].r = '0;
    assign rs[0].n = 64'(om) << 30;
    assign rs[0].r = '0;

    for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_root
        erc_sqrt_cell #(.STEP(j)) u_root_x (
            .aclk    (aclk),
            .en      (adv),
            .in_data (rx[j]),
            .out_data(rx[j+1])
        );
        erc_sqrt_cell #(.STEP(j)) u_root_e (
            .aclk    (aclk),
            .en      (adv),
            .in_data (rs[j]),
            .out_data(rs[j+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            xq_pipe_reg[1] <= xq_reg;
            for (int k = 2; k <= ROOT_STEPS; k++) begin
                xq_pipe_reg[k] <= xq_pipe_reg[k-1];
            end
        end
    end

    // roots rounded to nearest
    logic [31:0] r_reg;
    logic [31:0] q_reg;
    logic [32:0] xr_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            r_reg  <= 32'(rx[ROOT_STEPS].r + 64'(rx[ROOT_STEPS].n > rx[ROOT_STEPS].r));
            q_reg  <= 32'(rs[ROOT_STEPS].r + 64'(rs[ROOT_STEPS].n > rs[ROOT_STEPS].r));
            xr_reg <= xq_pipe_reg[ROOT_STEPS];
        end
    end

    // divisor and dividends
    logic [63:0] d_reg;
    logic [49:0] n0_reg;
    logic [49:0] n2_reg;
    logic [31:0] rm_reg;
    logic [32:0] xm_reg;
    logic [66:0] a_om;
    logic [65:0] a_sq;

    assign a_om = {33'd0, semi_reg} * {34'd0, om};
    assign a_sq = {32'd0, semi_reg} * {34'd0, q_reg};

    always_ff @(posedge aclk) begin
        if (adv) begin
            d_reg  <= 64'({31'd0, xr_reg} * {32'd0, r_reg});
            n0_reg <= a_om[65:16];
            n2_reg <= a_sq[64:15];
            rm_reg <= r_reg;
            xm_reg <= xr_reg;
        end
    end

    // division chains: meridional, transverse, conformal
    erc_pkg::div_lane_t dl [0:2][0:DIV_STEPS];

    always_comb begin
        dl[0][0].num = {n0_reg, 47'd0};
        dl[0][0].den = d_reg;
        dl[0][0].rem = '0;
        dl[0][0].quo = '0;
        dl[0][0].ovf = 1'b0;
        dl[1][0].num = erc_pkg::DIV_N_W'(semi_reg) << 31;
        dl[1][0].den = 64'(rm_reg);
        dl[1][0].rem = '0;
        dl[1][0].quo = '0;
        dl[1][0].ovf = 1'b0;
        dl[2][0].num = erc_pkg::DIV_N_W'(n2_reg) << 16;
        dl[2][0].den = 64'(xm_reg);
        dl[2][0].rem = '0;
        dl[2][0].quo = '0;
        dl[2][0].ovf = 1'b0;
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
        for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
            erc_div_cell #(.STEP(j)) u_div (
                .aclk    (aclk),
                .en      (adv),
                .in_data (dl[l][j]),
                .out_data(dl[l][j+1])
            );
        end
    end

    // round half up and saturate
    logic [erc_pkg::RAD_W-1:0] rad [0:2];
    logic [2:0]                sat;
    logic [2:0]                up;
    erc_pkg::result_t          res;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            up[l] = dl[l][DIV_STEPS].rem >= (dl[l][DIV_STEPS].den - dl[l][DIV_STEPS].rem);
            sat[l] = dl[l][DIV_STEPS].ovf || (up[l] && (&dl[l][DIV_STEPS].quo));
            rad[l] = sat[l] ? '1
                   : dl[l][DIV_STEPS].quo + erc_pkg::RAD_W'(up[l]);
        end
        res.meridional = rad[0];
        res.transverse = rad[1];
        res.conformal  = rad[2];
        res.saturated  = |sat;
    end

    // output register with a spare slot
    erc_pkg::result_t out_reg;
    erc_pkg::result_t out_next;
    erc_pkg::result_t spare_reg;
    erc_pkg::result_t spare_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             spare_valid_reg;
    logic             spare_valid_next;
    logic             out_fire;
    logic             pipe_out;

    assign adv      = !spare_valid_reg;
    assign out_fire = out_valid_reg && m_ready;
    assign pipe_out = vld_reg[PIPE_LAT-1] && adv;

    always_comb begin
        out_next         = out_reg;
        spare_next       = spare_reg;
        out_valid_next   = out_valid_reg;
        spare_valid_next = spare_valid_reg;
        if (spare_valid_reg) begin
            if (out_fire) begin
                out_next         = spare_reg;
                spare_valid_next = 1'b0;
            end
        end else if (pipe_out) begin
            if (!out_valid_reg || out_fire) begin
                out_next       = res;
                out_valid_next = 1'b1;
            end else begin
                spare_next       = res;
                spare_valid_next = 1'b1;
            end
        end else if (out_fire) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg   <= 1'b0;
            spare_valid_reg <= 1'b0;
        end else begin
            out_valid_reg   <= out_valid_next;
            spare_valid_reg <= spare_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg   <= out_next;
        spare_reg <= spare_next;
    end

    assign m_valid                = out_valid_reg;
    assign m_meridional_radius_mm = out_reg.meridional;
    assign m_transverse_radius_mm = out_reg.transverse;
    assign m_conformal_radius_mm  = out_reg.conformal;
    assign m_saturated            = out_reg.saturated;

endmodule
